// ===== sv/count_sorted_color_palette_unit_defines.svh =====
// Assertion macros for the color palette unit.
`ifndef COUNT_SORTED_COLOR_PALETTE_UNIT_DEFINES_SVH
`define COUNT_SORTED_COLOR_PALETTE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CSP_ASSERT(label, clk_i, rst_n_i, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) \
		else $error("assertion failed");
`define CSP_ASSERT_NEXT(label, clk_i, rst_n_i, pre, post) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define CSP_ASSERT(label, clk_i, rst_n_i, prop)
`define CSP_ASSERT_NEXT(label, clk_i, rst_n_i, pre, post)
`endif
`endif

// ===== sv/csp_pkg.sv =====
// Package: types and constants of the color palette unit.
package csp_pkg;
	localparam int PaletteDepth = 256;
	localparam int CountBits = 24;
	localparam logic [7:0] MaxColorsCap = 8'd254;

	localparam logic [1:0] ActInsert = 2'd0;
	localparam logic [1:0] ActClear = 2'd1;
	localparam logic [1:0] ActRead = 2'd2;
	localparam logic [1:0] ActUnused = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] pixel_color;
		logic [23:0] pixel_run;
		logic [7:0] read_index;
	} csp_in_t;

	typedef struct packed {
		logic [7:0] color_total;
		logic overflowed;
		logic [31:0] entry_color;
		logic [23:0] entry_pixels;
	} csp_out_t;
endpackage

// ===== sv/csp_mem.sv =====
// Palette memory: one slot of color and count per entry, registered read.
module csp_mem import csp_pkg::*; #(
	parameter int Depth = PaletteDepth,
	parameter int CntW = CountBits,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [31:0] wcolor,
	input logic [CntW-1:0] wcount,
	input logic [AW-1:0] raddr,
	output logic [31:0] rcolor,
	output logic [CntW-1:0] rcount
);
	logic [31:0] color_mem [Depth];
	logic [CntW-1:0] count_mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			color_mem[waddr] <= wcolor;
			count_mem[waddr] <= wcount;
		end
		rcolor <= color_mem[raddr];
		rcount <= count_mem[raddr];
	end
endmodule

// ===== sv/count_sorted_color_palette_unit.sv =====
// Top level: frequency-sorted color palette with sequencer over one memory.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready   | csp_in_t
//  out     | out | out_valid/out_ready | csp_out_t
//  cfg     | in  | cfg_valid/cfg_ready | max_colors (8 bits)
// Insert: a setup step, then a scan of the slots up to the match or the end, then
// a read and a write per entry moved plus the final write (the read is skipped when it
// lands in slot 0 directly), then a load of the result; the memory port is the bottleneck.
// Clear and unused actions go straight to the result load; read passes a memory read first.
// Reset is asynchronous; palette memory needs no clear. A stalled output holds
// the result while the next item waits.
`include "count_sorted_color_palette_unit_defines.svh"
module count_sorted_color_palette_unit import csp_pkg::*; #(
	parameter int PALETTE_DEPTH = PaletteDepth,
	parameter int COUNT_BITS = CountBits
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input csp_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output csp_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data
);
	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int NW = $clog2(PALETTE_DEPTH + 1);
	localparam logic [COUNT_BITS-1:0] CntMax = '1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_MOVE_RD, ST_MOVE_WR, ST_READ, ST_DONE
	} state_t;

	state_t state_q;
	logic [NW-1:0] used_q;
	logic [7:0] max_q;
	csp_in_t item_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [NW-1:0] pos_q;
	logic [NW-1:0] scan_q;
	logic scan_wait_q;
	logic out_valid_q;
	csp_out_t out_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wcolor, rcolor;
	logic [COUNT_BITS-1:0] wcount, rcount, run_sat, sum_sat;
	logic [COUNT_BITS:0] sum_w;
	logic [NW-1:0] limit;

	csp_mem #(.Depth(PALETTE_DEPTH), .CntW(COUNT_BITS)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wcolor(wcolor), .wcount(wcount),
		.raddr(raddr), .rcolor(rcolor), .rcount(rcount)
	);

	always_comb begin
		if (COUNT_BITS >= 24) run_sat = COUNT_BITS'(item_q.pixel_run);
		else if (|(32'(item_q.pixel_run) >> COUNT_BITS)) run_sat = CntMax;
		else run_sat = COUNT_BITS'(item_q.pixel_run);
		sum_w = {1'b0, rcount} + {1'b0, run_sat};
		sum_sat = sum_w[COUNT_BITS] ? CntMax : sum_w[COUNT_BITS-1:0];
		if (32'(max_q) > 32'(PALETTE_DEPTH)) limit = NW'(PALETTE_DEPTH);
		else limit = NW'(max_q);
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = pos_q[AW-1:0];
		wcolor = item_q.pixel_color;
		wcount = cnt_q;
		raddr = scan_q[AW-1:0];
		case (state_q)
			ST_MOVE_RD: raddr = AW'(pos_q - NW'(1));
			ST_MOVE_WR: begin
				we = 1'b1;
				if (pos_q == '0 || rcount >= cnt_q || scan_wait_q) begin
					wcolor = item_q.pixel_color;
					wcount = cnt_q;
				end else begin
					wcolor = rcolor;
					wcount = rcount;
				end
			end
			ST_READ: raddr = item_q.read_index[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			max_q <= MaxColorsCap;
			out_valid_q <= 1'b0;
			scan_wait_q <= 1'b0;
			pos_q <= '0;
			scan_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_q <= (cfg_data > MaxColorsCap) ? MaxColorsCap : cfg_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						scan_q <= '0;
						scan_wait_q <= 1'b1;
						case (in_data.action)
							ActInsert: state_q <= ST_SCAN;
							ActRead: state_q <= ST_READ;
							ActClear: begin
								used_q <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					// scan_wait_q: first cycle, no read data yet for slot scan_q
					if (scan_wait_q) begin
						if (scan_q >= used_q) begin
							if (used_q >= limit) begin
								used_q <= '0;
								state_q <= ST_DONE;
							end else begin
								cnt_q <= run_sat;
								pos_q <= used_q;
								used_q <= used_q + NW'(1);
								scan_wait_q <= (used_q == '0);
								state_q <= (used_q == '0) ? ST_MOVE_WR : ST_MOVE_RD;
							end
						end else begin
							scan_wait_q <= 1'b0;
							scan_q <= scan_q + NW'(1);
						end
					end else begin
						if (rcolor == item_q.pixel_color) begin
							cnt_q <= sum_sat;
							pos_q <= scan_q - NW'(1);
							state_q <= (scan_q == NW'(1)) ? ST_MOVE_WR : ST_MOVE_RD;
							scan_wait_q <= (scan_q == NW'(1));
						end else if (scan_q >= used_q) begin
							if (used_q >= limit) begin
								used_q <= '0;
								state_q <= ST_DONE;
							end else begin
								cnt_q <= run_sat;
								pos_q <= used_q;
								used_q <= used_q + NW'(1);
								state_q <= (used_q == '0) ? ST_MOVE_WR : ST_MOVE_RD;
								scan_wait_q <= (used_q == '0);
							end
						end else begin
							scan_q <= scan_q + NW'(1);
						end
					end
				end
				ST_MOVE_RD: state_q <= ST_MOVE_WR;
				ST_MOVE_WR: begin
					if (pos_q == '0 || rcount >= cnt_q || scan_wait_q) begin
						state_q <= ST_DONE;
					end else begin
						pos_q <= pos_q - NW'(1);
						state_q <= ST_MOVE_RD;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					out_q.color_total <= 8'(used_q);
					out_q.overflowed <= (item_q.action == ActInsert) && (used_q == '0);
					out_q.entry_color <= '0;
					out_q.entry_pixels <= '0;
					if (item_q.action == ActRead && NW'(item_q.read_index) < used_q
							&& 32'(item_q.read_index) < 32'(PALETTE_DEPTH)) begin
						out_q.entry_color <= rcolor;
						out_q.entry_pixels <= 24'(rcount);
					end
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CSP_ASSERT(a_used_bound, clk, arst_n, used_q <= NW'(PALETTE_DEPTH))
	`CSP_ASSERT(a_no_accept_busy, clk, arst_n, !(in_ready && state_q != ST_IDLE))
	`CSP_ASSERT_NEXT(a_done_out, clk, arst_n, state_q == ST_DONE, out_valid_q)
	`CSP_ASSERT(a_ovf_zero, clk, arst_n, !(out_valid_q && out_q.overflowed) || out_q.color_total == 8'd0)
endmodule
